### rtl/midrange_filter_3x3_macros.svh
// Assertion helpers used by mrf_back. Each macro expects clock and reset in scope.
`ifndef MIDRANGE_FILTER_3X3_MACROS_SVH
`define MIDRANGE_FILTER_3X3_MACROS_SVH

// Same-cycle implication.
`define MRF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MRF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mrf_pkg.sv
package mrf_pkg;

   localparam int CFG_BITS       = 10;
   localparam int POS_OUT_BITS   = 9;
   localparam int CSR_INDEX_BITS = 1;
   localparam int MIN_DIM        = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = 10'd512;
   localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = 10'd512;
   localparam logic [CFG_BITS-1:0] HEIGHT_LIMIT       = 10'd512;

   // Decisions made by the front for one item.
   typedef struct packed {
      logic                    fire;
      logic                    top;
      logic                    bot;
      logic                    left;
      logic                    right;
      logic                    last;
      logic [POS_OUT_BITS-1:0] row;
      logic [POS_OUT_BITS-1:0] col;
   } mrf_emit_type;

   typedef struct packed {
      logic [POS_OUT_BITS-1:0] row;
      logic [POS_OUT_BITS-1:0] col;
      logic                    last;
   } mrf_rsp_type;

endpackage

### rtl/mrf_fifo.sv
module mrf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    store_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### rtl/mrf_front.sv
module mrf_front #(
   parameter int MAX_WIDTH  = 512,
   parameter int PIXEL_BITS = 8,
   localparam int ADDR_BITS = $clog2(MAX_WIDTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [mrf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mrf_pkg::CFG_BITS-1:0]        csr_wdata,
   input  logic                                accept,
   input  logic                                mode,
   input  logic [PIXEL_BITS-1:0]               pixel_in,
   output logic [PIXEL_BITS-1:0]               item_val,
   output logic [ADDR_BITS-1:0]                item_col,
   output mrf_pkg::mrf_emit_type               item_emit
);

   import mrf_pkg::*;

   localparam int CNT_BITS = (ADDR_BITS + 1 > CFG_BITS) ? ADDR_BITS + 1 : CFG_BITS;
   localparam logic [CNT_BITS-1:0] WIDTH_MAX = CNT_BITS'(MAX_WIDTH);
   localparam logic [CNT_BITS-1:0] WIDTH_MIN = CNT_BITS'(MIN_DIM);
   localparam logic [CFG_BITS-1:0] HEIGHT_MIN = CFG_BITS'(MIN_DIM);

   logic [CFG_BITS-1:0]  frame_width_ff, frame_height_ff;
   logic [CFG_BITS-1:0]  in_row_ff, in_row_in;
   logic [ADDR_BITS-1:0] in_col_ff, in_col_in;
   logic [CFG_BITS-1:0]  emit_row_ff, emit_row_in;
   logic [ADDR_BITS-1:0] emit_col_ff, emit_col_in;

   logic [CNT_BITS-1:0]  width_ext, w_eff, in_col_inc, emit_col_inc;
   logic [CFG_BITS-1:0]  h_eff;
   logic                 fire, top, bot, left, right, last;

   always_comb begin
      width_ext = CNT_BITS'(frame_width_ff);
      if (width_ext < WIDTH_MIN) begin
         w_eff = WIDTH_MIN;
      end else if (width_ext > WIDTH_MAX) begin
         w_eff = WIDTH_MAX;
      end else begin
         w_eff = width_ext;
      end
      if (frame_height_ff < HEIGHT_MIN) begin
         h_eff = HEIGHT_MIN;
      end else if (frame_height_ff > HEIGHT_LIMIT) begin
         h_eff = HEIGHT_LIMIT;
      end else begin
         h_eff = frame_height_ff;
      end
   end

   assign fire  = (in_row_ff >= CFG_BITS'(2)) ||
                  ((in_row_ff == CFG_BITS'(1)) && (in_col_ff != '0));
   assign top   = (emit_row_ff == '0);
   assign bot   = (emit_row_ff >= h_eff - 1'b1);
   assign left  = (emit_col_ff == '0);
   assign right = (CNT_BITS'(emit_col_ff) >= w_eff - 1'b1);
   assign last  = fire && bot && right;

   assign in_col_inc   = CNT_BITS'(in_col_ff) + 1'b1;
   assign emit_col_inc = CNT_BITS'(emit_col_ff) + 1'b1;

   // Drain ticks carry zero into the line stores.
   assign item_val        = mode ? '0 : pixel_in;
   assign item_col        = in_col_ff;
   assign item_emit.fire  = fire;
   assign item_emit.top   = top;
   assign item_emit.bot   = bot;
   assign item_emit.left  = left;
   assign item_emit.right = right;
   assign item_emit.last  = last;
   assign item_emit.row   = POS_OUT_BITS'(emit_row_ff);
   assign item_emit.col   = POS_OUT_BITS'(emit_col_ff);

   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      emit_row_in = emit_row_ff;
      emit_col_in = emit_col_ff;
      if (in_col_inc >= w_eff) begin
         in_col_in = '0;
         in_row_in = in_row_ff + 1'b1;
      end else begin
         in_col_in = in_col_inc[ADDR_BITS-1:0];
      end
      if (last) begin
         // frame done: restart every position
         in_row_in   = '0;
         in_col_in   = '0;
         emit_row_in = '0;
         emit_col_in = '0;
      end else if (fire) begin
         if (emit_col_inc >= w_eff) begin
            emit_col_in = '0;
            emit_row_in = emit_row_ff + 1'b1;
         end else begin
            emit_col_in = emit_col_inc[ADDR_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         in_row_ff       <= '0;
         in_col_ff       <= '0;
         emit_row_ff     <= '0;
         emit_col_ff     <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            in_row_ff   <= in_row_in;
            in_col_ff   <= in_col_in;
            emit_row_ff <= emit_row_in;
            emit_col_ff <= emit_col_in;
         end
      end
   end

endmodule

### rtl/mrf_back.sv
`include "midrange_filter_3x3_macros.svh"

module mrf_back #(
   parameter int MAX_WIDTH  = 512,
   parameter int PIXEL_BITS = 8,
   localparam int ADDR_BITS = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  logic [PIXEL_BITS-1:0] q_val,
   input  logic [ADDR_BITS-1:0]  q_col,
   input  mrf_pkg::mrf_emit_type q_emit,
   output logic                  q_pop,
   input  logic                  out_full,
   output logic                  out_wr,
   output logic [PIXEL_BITS-1:0] out_pixel,
   output mrf_pkg::mrf_rsp_type  out_info
);

   import mrf_pkg::*;

   function automatic logic [PIXEL_BITS-1:0] max2(input logic [PIXEL_BITS-1:0] a,
                                                  input logic [PIXEL_BITS-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] min2(input logic [PIXEL_BITS-1:0] a,
                                                  input logic [PIXEL_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // Line stores: upper holds two rows back, lower one row back.
   logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];

   logic                  adv;
   logic                  a_valid_ff;
   logic [PIXEL_BITS-1:0] a_val_ff;
   logic [ADDR_BITS-1:0]  a_col_ff;
   mrf_emit_type          a_emit_ff;
   logic [PIXEL_BITS-1:0] upper_rd_ff, lower_rd_ff;
   logic                  bypass;

   logic                       c_valid_ff;
   mrf_emit_type               c_emit_ff;
   logic [8:0][PIXEL_BITS-1:0] window_ff, window_in;

   logic [8:0][PIXEL_BITS-1:0] masked;
   logic [2:0][PIXEL_BITS-1:0] row_max, row_min;
   logic [PIXEL_BITS-1:0]      all_max, all_min, min_sel;
   logic [PIXEL_BITS:0]        sum;
   logic                       border;

   // The whole back end moves in lockstep; hold while the result queue is full.
   assign adv   = !out_full;
   assign q_pop = adv && !q_empty;

   // Forward the upper-store write still in flight to a read at the same column.
   assign bypass = a_valid_ff && (a_col_ff == q_col);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         upper_rd_ff <= bypass ? lower_rd_ff : upper_mem[q_col];
      end
      if (adv && a_valid_ff) begin
         upper_mem[a_col_ff] <= lower_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         lower_rd_ff      <= lower_mem[q_col];
         lower_mem[q_col] <= q_val;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_val_ff  <= q_val;
         a_col_ff  <= q_col;
         a_emit_ff <= q_emit;
      end
      if (adv && a_valid_ff) begin
         c_emit_ff <= a_emit_ff;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         window_in[r*3 + 0] = window_ff[r*3 + 1];
         window_in[r*3 + 1] = window_ff[r*3 + 2];
      end
      window_in[2] = upper_rd_ff;
      window_in[5] = lower_rd_ff;
      window_in[8] = a_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         window_ff  <= '0;
      end else if (adv) begin
         a_valid_ff <= !q_empty;
         c_valid_ff <= a_valid_ff;
         if (a_valid_ff) begin
            window_ff <= window_in;
         end
      end
   end

   // Drop neighbors outside the frame; zero never beats the center in a max.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((r == 0 && c_emit_ff.top) || (r == 2 && c_emit_ff.bot) ||
                (c == 0 && c_emit_ff.left) || (c == 2 && c_emit_ff.right)) begin
               masked[r*3 + c] = '0;
            end else begin
               masked[r*3 + c] = window_ff[r*3 + c];
            end
         end
      end
      for (int r = 0; r < 3; r++) begin
         row_max[r] = max2(max2(masked[r*3], masked[r*3 + 1]), masked[r*3 + 2]);
         row_min[r] = min2(min2(window_ff[r*3], window_ff[r*3 + 1]), window_ff[r*3 + 2]);
      end
      all_max = max2(max2(row_max[0], row_max[1]), row_max[2]);
      all_min = min2(min2(row_min[0], row_min[1]), row_min[2]);
      border  = c_emit_ff.top || c_emit_ff.bot || c_emit_ff.left || c_emit_ff.right;
      min_sel = border ? '0 : all_min;
      sum     = {1'b0, all_max} + {1'b0, min_sel};
   end

   assign out_wr        = adv && c_valid_ff && c_emit_ff.fire;
   assign out_pixel     = sum[PIXEL_BITS:1];
   assign out_info.row  = c_emit_ff.row;
   assign out_info.col  = c_emit_ff.col;
   assign out_info.last = c_emit_ff.last;

   `MRF_ASSERT_IMP(a_no_overrun, out_wr, !out_full, "result written into a full queue")
   `MRF_ASSERT_IMP(a_last_fires, c_valid_ff && c_emit_ff.last, c_emit_ff.fire, "last without fire")
   `MRF_ASSERT_NXT(a_stall_holds, !adv, $stable(window_ff) && $stable(c_valid_ff), "window moved")

endmodule

### rtl/midrange_filter_3x3.sv
// Channel  Direction  Handshake              Payload
// req      in         push / full            req_mode, req_pixel_in
// rsp      out        empty / pop            rsp_pixel_out, rsp_out_row, rsp_out_col, rsp_frame_last
// csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One item per clock sustained while the result queue has room; a result passes through the
// item queue, line store read, window update and result queue write before it shows on rsp.
// Reset is synchronous; the line stores are not cleared and need no clearing pass.
// A full result queue stalls the back end; a full item queue then raises full.
// csr_ready is always high.
module midrange_filter_3x3 #(
   parameter int MAX_WIDTH  = 512,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_mode,
   input  logic [PIXEL_BITS-1:0]               req_pixel_in,
   output logic                                empty,
   input  logic                                pop,
   output logic [PIXEL_BITS-1:0]               rsp_pixel_out,
   output logic [mrf_pkg::POS_OUT_BITS-1:0]    rsp_out_row,
   output logic [mrf_pkg::POS_OUT_BITS-1:0]    rsp_out_col,
   output logic                                rsp_frame_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mrf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mrf_pkg::CFG_BITS-1:0]        csr_wdata
);

   import mrf_pkg::*;

   localparam int ADDR_BITS = $clog2(MAX_WIDTH);
   localparam int EMIT_BITS = $bits(mrf_emit_type);
   localparam int RSP_BITS  = $bits(mrf_rsp_type);
   localparam int Q_BITS    = PIXEL_BITS + ADDR_BITS + EMIT_BITS;
   localparam int OUT_BITS  = PIXEL_BITS + RSP_BITS;

   logic                  accept;
   logic [PIXEL_BITS-1:0] item_val;
   logic [ADDR_BITS-1:0]  item_col;
   mrf_emit_type          item_emit;

   logic                  q_empty, q_pop;
   logic [Q_BITS-1:0]     q_rdata;
   logic [PIXEL_BITS-1:0] q_val;
   logic [ADDR_BITS-1:0]  q_col;
   mrf_emit_type          q_emit;

   logic                  out_full, out_wr;
   logic [PIXEL_BITS-1:0] out_pixel;
   mrf_rsp_type           out_info, rsp_info;
   logic [OUT_BITS-1:0]   out_rdata;

   assign accept    = push && !full;
   assign csr_ready = 1'b1;

   mrf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .mode      (req_mode),
      .pixel_in  (req_pixel_in),
      .item_val  (item_val),
      .item_col  (item_col),
      .item_emit (item_emit)
   );

   mrf_fifo #(
      .WIDTH (Q_BITS),
      .DEPTH (4)
   ) u_item_q (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata ({item_val, item_col, item_emit}),
      .full  (full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign {q_val, q_col, q_emit} = q_rdata;

   mrf_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_val     (q_val),
      .q_col     (q_col),
      .q_emit    (q_emit),
      .q_pop     (q_pop),
      .out_full  (out_full),
      .out_wr    (out_wr),
      .out_pixel (out_pixel),
      .out_info  (out_info)
   );

   mrf_fifo #(
      .WIDTH (OUT_BITS),
      .DEPTH (4)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_wr),
      .wdata ({out_pixel, out_info}),
      .full  (out_full),
      .pop   (pop),
      .rdata (out_rdata),
      .empty (empty)
   );

   assign {rsp_pixel_out, rsp_info} = out_rdata;
   assign rsp_out_row    = rsp_info.row;
   assign rsp_out_col    = rsp_info.col;
   assign rsp_frame_last = rsp_info.last;

endmodule
